// File: hdl/md5_pkg.sv
package md5_pkg;

  // Input word kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_LAST = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Initial chaining values
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  // Padding constants
  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] LEN_OFFSET  = 6'd56;
  localparam logic [5:0] BLOCK_LAST  = 6'd63;
  localparam logic [5:0] ROUND_LAST  = 6'd63;
  localparam logic [1:0] WORD_LAST   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Four working or chaining words
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } abcd_t;

  // Sine-derived additive constant of each round
  function automatic logic [31:0] md5_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Left-rotate amount of each round
  function automatic logic [4:0] md5_rot(input logic [5:0] idx);
    logic [4:0] s;
    unique case ({idx[5:4], idx[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word used by each round, all arithmetic mod 16
  function automatic logic [3:0] md5_g(input logic [5:0] idx);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = idx[3:0];
    unique case (idx[5:4])
      2'd0: g = r4;
      2'd1: g = r4 + {r4[1:0], 2'b00} + 4'd1;
      2'd2: g = r4 + {r4[2:0], 1'b0} + 4'd5;
      2'd3: g = {r4[0], 3'b000} - r4;
    endcase
    return g;
  endfunction

endpackage

// File: hdl/md5_msg_buf.sv
module md5_msg_buf
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_addr_i,
  input  logic [7:0]  wr_data_i,
  input  logic [3:0]  rd_addr_i,
  output logic [31:0] rd_data_o
);

  // 16 little-endian words, written a byte lane at a time
  logic [3:0][7:0] mem_q [16];
  logic [31:0]     rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i[5:2]][wr_addr_i[1:0]] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: hdl/md5_round.sv
module md5_round
  import md5_pkg::*;
(
  input  logic [5:0]  round_i,
  input  abcd_t       work_i,
  input  logic [31:0] pre_i,    // a + K + M, registered ahead of the round
  output abcd_t       work_o
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [4:0]  sh;

  // Round function for the current quarter
  always_comb begin
    unique case (round_i[5:4])
      2'd0: f = work_i.d ^ (work_i.b & (work_i.c ^ work_i.d));
      2'd1: f = (work_i.d & work_i.b) | (~work_i.d & work_i.c);
      2'd2: f = work_i.b ^ work_i.c ^ work_i.d;
      2'd3: f = work_i.c ^ (work_i.b | ~work_i.d);
    endcase
  end

  // Add, rotate, add, then shift the word order
  assign sh  = md5_rot(round_i);
  assign sum = pre_i + f;
  assign dbl = {sum, sum} << sh;

  assign work_o.a = work_i.d;
  assign work_o.b = work_i.b + dbl[63:32];
  assign work_o.c = work_i.b;
  assign work_o.d = work_i.c;

endmodule

// File: hdl/md5_message_digest.sv
// MD5 digest engine, one message byte per input word.
// Input channel (in_valid_i / in_stall_o / in_word_i): kind 0 is a data byte,
// kind 1 a final data byte, kind 2 ends the message without a byte; kind 3
// is taken and ignored. Output channel (out_valid_o / out_stall_i /
// out_word_o) gives four words, A..D, the last flagged by last_word.
// The byte that fills a 64-byte block holds the input stalled while the
// block is compressed: ST_LOAD and ST_PRE prime the message-word read, 64
// rounds run through the single shared round unit (one per cycle), and
// ST_ADD updates the chaining words. Ending a message writes padding and
// length into the block buffer byte by byte in ST_PAD (up to two blocks of
// compression), then offers the four digest words, one per cycle the
// receiver does not stall. The input stays stalled until word D is taken;
// a stalled output word holds steady. Reset loads the initial chaining words
// and clears the byte count; the block buffer needs no clearing.
module md5_message_digest
  import md5_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LOAD, ST_PRE, ST_ROUND, ST_ADD, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_ONE, PH_ZERO, PH_LEN
  } pad_ph_e;

  state_e      state_q;
  pad_ph_e     pad_ph_q;
  logic        pad_act_q;
  logic [63:0] count_q;
  logic [63:0] bits_q;
  logic [5:0]  round_q;
  logic [1:0]  idx_q;
  abcd_t       chain_q;
  abcd_t       work_q;
  abcd_t       work_nx;
  logic [31:0] pre_q;

  logic        wr_en;
  logic [7:0]  wr_data;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  logic [31:0] pre_base;
  logic [5:0]  k_idx;
  logic [5:0]  low6;
  logic        in_acc;
  logic        out_acc;

  assign low6    = count_q[5:0];
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  md5_msg_buf u_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (low6),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  md5_round u_round (
    .round_i (round_q),
    .work_i  (work_q),
    .pre_i   (pre_q),
    .work_o  (work_nx)
  );

  // Buffer write: message bytes when idle, padding bytes in ST_PAD
  always_comb begin
    wr_en   = 1'b0;
    wr_data = in_word_i.data_byte;
    if (state_q == ST_IDLE) begin
      wr_en = in_acc && (in_word_i.kind == KIND_DATA || in_word_i.kind == KIND_LAST);
    end else if (state_q == ST_PAD) begin
      case (pad_ph_q)
        PH_ONE: begin
          wr_en   = 1'b1;
          wr_data = PAD_MARK;
        end
        PH_ZERO: begin
          wr_en   = (low6 != LEN_OFFSET);
          wr_data = 8'h00;
        end
        default: begin
          wr_en   = 1'b1;
          wr_data = bits_q[{low6[2:0], 3'b000} +: 8];
        end
      endcase
    end
  end

  // Message-word read runs two rounds ahead; pre-sum one round ahead
  always_comb begin
    rd_addr  = md5_g(round_q + 6'd2);
    pre_base = work_q.d;
    k_idx    = round_q + 6'd1;
    if (state_q == ST_LOAD) begin
      rd_addr = md5_g(6'd0);
    end else if (state_q == ST_PRE) begin
      rd_addr  = md5_g(6'd1);
      pre_base = work_q.a;
      k_idx    = 6'd0;
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pad_ph_q  <= PH_ONE;
      pad_act_q <= 1'b0;
      count_q   <= '0;
      round_q   <= '0;
      idx_q     <= '0;
      chain_q   <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
    end else begin
      if (wr_en) begin
        count_q <= count_q + 64'd1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_word_i.kind)
              KIND_DATA: begin
                if (low6 == BLOCK_LAST) begin
                  pad_act_q <= 1'b0;
                  state_q   <= ST_LOAD;
                end
              end
              KIND_LAST: begin
                bits_q    <= {count_q[60:0] + 61'd1, 3'b000};
                pad_act_q <= 1'b1;
                pad_ph_q  <= PH_ONE;
                state_q   <= (low6 == BLOCK_LAST) ? ST_LOAD : ST_PAD;
              end
              KIND_END: begin
                bits_q    <= {count_q[60:0], 3'b000};
                pad_act_q <= 1'b1;
                pad_ph_q  <= PH_ONE;
                state_q   <= ST_PAD;
              end
              default: ;
            endcase
          end
        end
        ST_PAD: begin
          case (pad_ph_q)
            PH_ONE:  pad_ph_q <= PH_ZERO;
            PH_ZERO: if (low6 == LEN_OFFSET) pad_ph_q <= PH_LEN;
            default: ;
          endcase
          if (wr_en && low6 == BLOCK_LAST) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          work_q  <= chain_q;
          round_q <= '0;
          state_q <= ST_PRE;
        end
        ST_PRE: begin
          pre_q   <= pre_base + md5_k(k_idx) + rd_data;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          work_q  <= work_nx;
          pre_q   <= pre_base + md5_k(k_idx) + rd_data;
          round_q <= round_q + 6'd1;
          if (round_q == ROUND_LAST) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          chain_q.a <= chain_q.a + work_q.a;
          chain_q.b <= chain_q.b + work_q.b;
          chain_q.c <= chain_q.c + work_q.c;
          chain_q.d <= chain_q.d + work_q.d;
          idx_q     <= '0;
          if (!pad_act_q) begin
            state_q <= ST_IDLE;
          end else if (pad_ph_q == PH_LEN) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == WORD_LAST) begin
              chain_q   <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
              count_q   <= '0;
              pad_act_q <= 1'b0;
              state_q   <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Digest word select
  always_comb begin
    out_word_o.digest_word = chain_q.a;
    case (idx_q)
      2'd1:    out_word_o.digest_word = chain_q.b;
      2'd2:    out_word_o.digest_word = chain_q.c;
      2'd3:    out_word_o.digest_word = chain_q.d;
      default: ;
    endcase
  end

  assign out_word_o.word_index = idx_q;
  assign out_word_o.last_word  = (idx_q == WORD_LAST);
  assign out_valid_o           = (state_q == ST_OUT);
  assign in_stall_o            = (state_q != ST_IDLE);

  // Input is never taken while digest words are pending
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input ready while digest pending");

  // Filling a block starts compression
  a_full_block_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.kind == KIND_DATA && count_q[5:0] == BLOCK_LAST)
      |=> (in_stall_o && state_q == ST_LOAD))
    else $error("full block did not start compression");

  // Taking word D frees the input and restarts the count
  a_last_word_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_word_o.last_word) |=> (!in_stall_o && count_q == 64'd0))
    else $error("engine not reinitialized after digest");

  // Digest is offered only after the length bytes closed a block
  a_out_after_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_ADD && pad_ph_q == PH_LEN
                            && count_q[5:0] == 6'd0))
    else $error("digest offered before padding finished");

endmodule

// File: tb/md5_digest_calc_pkg.sv
package md5_digest_calc_pkg;
  import md5_pkg::*;

  // Kind code the block takes and drops
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Running MD5 of the byte stream plus the queue of digest words still due
  class md5_digest_calc;
    local bit [31:0] sine_k [64];
    local int unsigned rot_by [16];
    local bit [31:0] chain [4];
    local bit [7:0] block_bytes [64];
    local bit [63:0] byte_total;
    local out_word_t digests_due [$];

    int unsigned errors;
    int unsigned words_taken;
    int unsigned words_ignored;
    int unsigned messages_done;
    int unsigned digest_words_seen;

    function new();
      sine_k = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
      };
      // rotate amounts, four per group of 16 rounds
      rot_by = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      errors = 0;
      words_taken = 0;
      words_ignored = 0;
      messages_done = 0;
      digest_words_seen = 0;
      restart_chain();
    endfunction

    local function void restart_chain();
      chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
      byte_total = '0;
    endfunction

    // 64 rounds over the buffered block, then fold into the chain
    local function void compress_block();
      bit [31:0] m [16];
      bit [31:0] a, b, c, d, f, sum, rot, tmp;
      int unsigned g, sh;
      for (int i = 0; i < 16; i++) begin
        m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
      end
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        case (r / 16)
          0: begin
            f = d ^ (b & (c ^ d));
            g = r;
          end
          1: begin
            f = (d & b) | (~d & c);
            g = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
          end
        endcase
        sh = rot_by[(r / 16) * 4 + (r % 4)];
        sum = a + f + sine_k[r] + m[g];
        rot = (sum << sh) | (sum >> (32 - sh));
        tmp = d;
        d = c;
        c = b;
        b = b + rot;
        a = tmp;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    local function void push_byte(bit [7:0] v);
      block_bytes[byte_total[5:0]] = v;
      byte_total++;
      if (byte_total[5:0] == 6'd0) compress_block();
    endfunction

    // pad, append the bit length, queue A..D, start over
    local function void finish_message();
      bit [63:0] bit_len;
      out_word_t w;
      bit_len = byte_total << 3;
      push_byte(PAD_MARK);
      while (byte_total[5:0] != LEN_OFFSET) push_byte(8'h00);
      for (int k = 0; k < 8; k++) push_byte(bit_len[8*k +: 8]);
      for (int k = 0; k < 4; k++) begin
        w.digest_word = chain[k];
        w.word_index = 2'(k);
        w.last_word = (k == 3);
        digests_due.push_back(w);
      end
      restart_chain();
      messages_done++;
    endfunction

    // accepted input word
    function void take_word(in_word_t w);
      case (w.kind)
        KIND_DATA: push_byte(w.data_byte);
        KIND_LAST: begin
          push_byte(w.data_byte);
          finish_message();
        end
        KIND_END: finish_message();
        default: words_ignored++;
      endcase
      if (w.kind != KIND_UNUSED) words_taken++;
    endfunction

    // accepted output word against the oldest one due
    function void check_digest_word(out_word_t got);
      out_word_t want;
      if (digests_due.size() == 0) begin
        $error("digest word %h (index %0d) with none expected", got.digest_word,
               got.word_index);
        errors++;
        return;
      end
      want = digests_due.pop_front();
      digest_words_seen++;
      if (got.digest_word !== want.digest_word) begin
        $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
        errors++;
      end
      if (got.word_index !== want.word_index) begin
        $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
        errors++;
      end
      if (got.last_word !== want.last_word) begin
        $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return digests_due.size();
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
module tb_top;
  import md5_pkg::*;
  import md5_digest_calc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 300;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  md5_digest_calc calc;

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_used = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned phase_items;

  md5_message_digest dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: one long hold on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // both handshakes, sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) calc.check_digest_word(out_word_o);
      if (in_valid_i && !in_stall_o) calc.take_word(in_word_i);
    end
  end

  // offer one word after a random gap, return at the edge that takes it
  task automatic send_word(logic [1:0] kind, logic [7:0] data);
    in_word_t w;
    w.kind = kind;
    w.data_byte = data;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (kind != KIND_UNUSED) phase_items++;
  endtask

  // random message of len bytes, ended by a flagged last byte or an end word
  task automatic send_message(int unsigned len);
    bit flag_last;
    flag_last = (len != 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_word(KIND_UNUSED, 8'($urandom_range(255)));
      send_word((flag_last && i == len - 1) ? KIND_LAST : KIND_DATA,
                8'($urandom_range(255)));
    end
    if (!flag_last) send_word(KIND_END, 8'($urandom_range(255)));
  endtask

  // short messages, then an optional longer one across the padding boundary
  task automatic run_phase(int unsigned gap, int unsigned stall, int unsigned tail_len);
    send_gap_pct = gap;
    stall_pct = stall;
    phase_items = 0;
    while (phase_items < 10) send_message($urandom_range(9));
    if (tail_len != 0) send_message(tail_len);
  endtask

  initial begin
    calc = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty message, dropped kind, single bytes at both extremes
    send_word(KIND_END, 8'hff);
    send_word(KIND_UNUSED, 8'hff);
    send_word(KIND_UNUSED, 8'h00);
    send_word(KIND_LAST, 8'h00);
    send_word(KIND_LAST, 8'hff);
    // "abc"
    send_word(KIND_DATA, 8'h61);
    send_word(KIND_DATA, 8'h62);
    send_word(KIND_LAST, 8'h63);
    // dropped kind inside a message, then end without a byte
    send_word(KIND_DATA, 8'h00);
    send_word(KIND_UNUSED, 8'haa);
    send_word(KIND_DATA, 8'hff);
    send_word(KIND_END, 8'h00);
    // two empty messages back to back
    send_word(KIND_END, 8'h00);
    send_word(KIND_END, 8'h55);

    // long output hold while input keeps coming
    hold_req = 1'b1;
    send_message(3);
    send_message(5);
    send_message(0);

    run_phase(0, 0, 0);
    run_phase(81, 0, 0);
    run_phase(0, 81, $urandom_range(70, 56));
    run_phase(19, 19, 0);
    in_valid_i <= 1'b0;

    while (calc.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d messages from %0d input words (%0d dropped kind words),",
             calc.messages_done, calc.words_taken, calc.words_ignored);
    $display("with %0d digest words checked under gaps, stalls and one long hold.",
             calc.digest_words_seen);
    if (calc.errors == 0 && calc.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
